### rtl/vpr_pkg.sv
package vpr_pkg;

   // field widths
   localparam int SAMPLE_W = 16;
   localparam int LEN_W    = 7;

   // internal arithmetic widths
   localparam int NORM_W = 37;
   localparam int DOT_W  = 38;
   localparam int COEF_W = 32;
   localparam int PROD_W = COEF_W + SAMPLE_W;
   localparam int FRAC_W = 16;
   localparam int DEN_W  = NORM_W + 1;
   localparam int NUM_W  = DOT_W + FRAC_W + 1;

   // coefficient saturation limits
   localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

   // residual saturation limits
   localparam logic signed [SAMPLE_W-1:0] RES_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] RES_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [LEN_W-1:0]           length_type;

endpackage

### rtl/vpr_channels.sv
// request channel: one shape or clip element
interface vpr_req_if;
   import vpr_pkg::*;
   logic       valid;
   logic       ready;
   logic       mode;
   sample_type sample;

   modport source (output valid, output mode, output sample, input ready);
   modport sink   (input valid, input mode, input sample, output ready);
endinterface

// result channel: one residual element
interface vpr_rsp_if;
   import vpr_pkg::*;
   logic       valid;
   logic       ready;
   sample_type residual;
   logic       last_element;

   modport source (output valid, output residual, output last_element, input ready);
   modport sink   (input valid, input residual, input last_element, output ready);
endinterface

// register write channel: vector length
interface vpr_csr_if;
   import vpr_pkg::*;
   logic       valid;
   logic       ready;
   length_type vector_length;

   modport source (output valid, output vector_length, input ready);
   modport sink   (input valid, input vector_length, output ready);
endinterface

### rtl/vector_projection_removal.sv
// Removes from each clip vector its projection onto a stored shape vector. Mode 0 requests
// load shape elements and build the squared norm; mode 1 requests buffer clip elements and
// build the dot product with the shape. Every request passes through accept, multiply and
// accumulate states on one shared 32x16 multiplier, and the block is not ready meanwhile.
// The request that completes a clip vector then runs the restoring divider (setup, steps,
// coefficient) that forms the Q16 coefficient (one quotient bit per cycle; skipped when
// the norm is zero) and emits each element through memory read, multiply and residual,
// waiting while the result side holds off, until the last element is sent. A result may
// still wait in the output register while the next request is taken. The shape store reads
// as zero after reset through per-entry valid bits, so no clearing pass is needed.
module vector_projection_removal #(
   parameter int MAX_VECTOR_LENGTH = 64
) (
   input logic        clock,
   input logic        reset,
   vpr_req_if.sink    req_channel,
   vpr_rsp_if.source  rsp_channel,
   vpr_csr_if.sink    csr_channel
);
   import vpr_pkg::*;

   localparam int ADDR_W = (MAX_VECTOR_LENGTH > 1) ? $clog2(MAX_VECTOR_LENGTH) : 1;
   localparam int CNT_W  = $clog2(NUM_W);
   localparam logic [LEN_W-1:0]  MAX_LEN  = LEN_W'(MAX_VECTOR_LENGTH);
   localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(NUM_W - 1);
   localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_W - 1);

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_ITEM_MUL  = 9'b000000010,
      ST_ITEM_ACC  = 9'b000000100,
      ST_DIV_SETUP = 9'b000001000,
      ST_DIV_STEP  = 9'b000010000,
      ST_COEF      = 9'b000100000,
      ST_EMIT_READ = 9'b001000000,
      ST_EMIT_MUL  = 9'b010000000,
      ST_EMIT_RES  = 9'b100000000
   } state_type;

   // control registers
   state_type                  state_ff, state_in;
   length_type                 length_ff;
   logic [ADDR_W-1:0]          shape_pos_ff, shape_pos_in;
   logic [ADDR_W-1:0]          clip_pos_ff, clip_pos_in;
   logic [ADDR_W-1:0]          k_ff, k_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [NORM_W-1:0]          norm_run_ff, norm_run_in;
   logic [NORM_W-1:0]          norm_sq_ff, norm_sq_in;
   logic signed [DOT_W-1:0]    dot_ff, dot_in;
   logic [MAX_VECTOR_LENGTH-1:0] shape_valid_ff;
   logic                       rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic                       mode_ff;
   sample_type                 sample_ff;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic [NUM_W-1:0]           num_ff, num_in;
   logic [DEN_W-1:0]           rem_ff, rem_in;
   logic                       neg_ff, neg_in;
   logic signed [COEF_W-1:0]   coef_ff, coef_in;
   sample_type                 residual_ff, residual_in;
   logic                       last_ff, last_in;

   // memories
   sample_type                 shape_mem [MAX_VECTOR_LENGTH];
   sample_type                 clip_mem  [MAX_VECTOR_LENGTH];
   sample_type                 shape_rd_ff;
   logic                       shape_vld_rd_ff;
   sample_type                 clip_rd_ff;
   logic [ADDR_W-1:0]          shape_raddr;

   // combinational helpers
   logic                       req_ready;
   logic                       req_acc;
   logic                       rsp_free;
   length_type                 len_act;
   logic                       shape_done;
   logic                       clip_done;
   logic                       k_last;
   sample_type                 shape_data;
   logic signed [COEF_W-1:0]   mul_a;
   sample_type                 mul_b;
   logic [NORM_W-1:0]          norm_sum;
   logic signed [DOT_W-1:0]    dot_sum;
   logic [DOT_W-1:0]           dot_mag;
   logic [DEN_W:0]             trial;
   logic [DEN_W:0]             den_ext;
   logic                       qbit;
   logic                       prod_neg;
   logic [PROD_W-1:0]          prod_mag;
   logic [PROD_W-1:0]          prod_rnd;
   logic signed [COEF_W:0]     proj;
   logic signed [COEF_W+1:0]   diff;
   sample_type                 res_calc;

   // handshakes
   assign req_ready         = (state_ff == ST_IDLE);
   assign req_acc           = req_channel.valid && req_ready;
   assign req_channel.ready = req_ready;
   assign csr_channel.ready = 1'b1;
   assign rsp_free          = !rsp_valid_ff || rsp_channel.ready;

   assign rsp_channel.valid        = rsp_valid_ff;
   assign rsp_channel.residual     = residual_ff;
   assign rsp_channel.last_element = last_ff;

   // effective vector length and end-of-vector tests
   assign len_act    = (length_ff == '0 || length_ff > MAX_LEN) ? MAX_LEN : length_ff;
   assign shape_done = ((LEN_W+1)'(shape_pos_ff) + (LEN_W+1)'(1)) >= {1'b0, len_act};
   assign clip_done  = ((LEN_W+1)'(clip_pos_ff) + (LEN_W+1)'(1)) >= {1'b0, len_act};
   assign k_last     = ((LEN_W+1)'(k_ff) + (LEN_W+1)'(1)) == {1'b0, len_act};

   // shape entries never written read as zero
   assign shape_data = shape_vld_rd_ff ? shape_rd_ff : '0;

   // shared multiplier operand selection
   assign mul_a   = (state_ff == ST_EMIT_MUL) ? coef_ff : COEF_W'(sample_ff);
   assign mul_b   = (state_ff == ST_ITEM_MUL && !mode_ff) ? sample_ff : shape_data;
   assign prod_in = mul_a * mul_b;

   // accumulators
   assign norm_sum = norm_run_ff + prod_ff[NORM_W-1:0];
   assign dot_sum  = dot_ff + $signed(prod_ff[DOT_W-1:0]);
   assign dot_mag  = dot_ff[DOT_W-1] ? DOT_W'(-dot_ff) : DOT_W'(dot_ff);

   // restoring divider step
   assign trial   = {rem_ff, num_ff[NUM_W-1]};
   assign den_ext = {1'b0, norm_sq_ff, 1'b0};
   assign qbit    = (trial >= den_ext);

   // projection rounding and residual saturation
   assign prod_neg = prod_ff[PROD_W-1];
   assign prod_mag = prod_neg ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
   assign prod_rnd = prod_mag + RND_HALF;
   assign proj     = prod_neg ? -$signed({1'b0, prod_rnd[FRAC_W +: COEF_W]})
                              :  $signed({1'b0, prod_rnd[FRAC_W +: COEF_W]});
   assign diff     = (COEF_W+2)'(clip_rd_ff) - (COEF_W+2)'(proj);

   always_comb begin
      if (norm_sq_ff == '0) begin
         res_calc = clip_rd_ff;
      end else if (diff > (COEF_W+2)'(RES_MAX)) begin
         res_calc = RES_MAX;
      end else if (diff < (COEF_W+2)'(RES_MIN)) begin
         res_calc = RES_MIN;
      end else begin
         res_calc = diff[SAMPLE_W-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      shape_pos_in = shape_pos_ff;
      clip_pos_in  = clip_pos_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      norm_run_in  = norm_run_ff;
      norm_sq_in   = norm_sq_ff;
      dot_in       = dot_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      coef_in      = coef_ff;
      residual_in  = residual_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_channel.ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_ITEM_MUL;
            end
         end
         ST_ITEM_MUL: begin
            state_in = ST_ITEM_ACC;
         end
         ST_ITEM_ACC: begin
            if (!mode_ff) begin
               state_in = ST_IDLE;
               if (shape_done) begin
                  norm_sq_in   = norm_sum;
                  norm_run_in  = '0;
                  shape_pos_in = '0;
               end else begin
                  norm_run_in  = norm_sum;
                  shape_pos_in = shape_pos_ff + ADDR_W'(1);
               end
            end else begin
               dot_in = dot_sum;
               if (clip_done) begin
                  clip_pos_in = '0;
                  state_in    = ST_DIV_SETUP;
               end else begin
                  clip_pos_in = clip_pos_ff + ADDR_W'(1);
                  state_in    = ST_IDLE;
               end
            end
         end
         ST_DIV_SETUP: begin
            num_in = {dot_mag, {(FRAC_W+1){1'b0}}} + NUM_W'(norm_sq_ff);
            rem_in = '0;
            cnt_in = '0;
            neg_in = dot_ff[DOT_W-1];
            dot_in = '0;
            k_in   = '0;
            state_in = (norm_sq_ff == '0) ? ST_EMIT_READ : ST_DIV_STEP;
         end
         ST_DIV_STEP: begin
            rem_in = qbit ? DEN_W'(trial - den_ext) : DEN_W'(trial);
            num_in = {num_ff[NUM_W-2:0], qbit};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_COEF;
            end
         end
         ST_COEF: begin
            if (!neg_ff) begin
               coef_in = (num_ff > NUM_W'(COEF_MAX)) ? COEF_MAX : $signed(num_ff[COEF_W-1:0]);
            end else begin
               coef_in = (num_ff > NUM_W'(unsigned'(COEF_MIN))) ? COEF_MIN
                                                                 : -$signed(num_ff[COEF_W-1:0]);
            end
            state_in = ST_EMIT_READ;
         end
         ST_EMIT_READ: begin
            state_in = ST_EMIT_MUL;
         end
         ST_EMIT_MUL: begin
            state_in = ST_EMIT_RES;
         end
         ST_EMIT_RES: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               residual_in  = res_calc;
               last_in      = k_last;
               if (k_last) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + ADDR_W'(1);
                  state_in = ST_EMIT_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         length_ff      <= MAX_LEN;
         shape_pos_ff   <= '0;
         clip_pos_ff    <= '0;
         k_ff           <= '0;
         cnt_ff         <= '0;
         norm_run_ff    <= '0;
         norm_sq_ff     <= '0;
         dot_ff         <= '0;
         shape_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         shape_pos_ff <= shape_pos_in;
         clip_pos_ff  <= clip_pos_in;
         k_ff         <= k_in;
         cnt_ff       <= cnt_in;
         norm_run_ff  <= norm_run_in;
         norm_sq_ff   <= norm_sq_in;
         dot_ff       <= dot_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_channel.valid) begin
            length_ff <= csr_channel.vector_length;
         end
         if (req_acc && !req_channel.mode) begin
            shape_valid_ff[shape_pos_ff] <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         mode_ff   <= req_channel.mode;
         sample_ff <= req_channel.sample;
      end
      // product held while a residual waits for the output register
      if (state_ff == ST_ITEM_MUL || state_ff == ST_EMIT_MUL) begin
         prod_ff <= prod_in;
      end
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      neg_ff      <= neg_in;
      coef_ff     <= coef_in;
      residual_ff <= residual_in;
      last_ff     <= last_in;
   end

   // shape store, read for dot product or emission
   assign shape_raddr = (state_ff == ST_EMIT_READ) ? k_ff : clip_pos_ff;

   always_ff @(posedge clock) begin
      if (req_acc && !req_channel.mode) begin
         shape_mem[shape_pos_ff] <= req_channel.sample;
      end
      shape_rd_ff     <= shape_mem[shape_raddr];
      shape_vld_rd_ff <= shape_valid_ff[shape_raddr];
   end

   // clip store, read during emission
   always_ff @(posedge clock) begin
      if (req_acc && req_channel.mode) begin
         clip_mem[clip_pos_ff] <= req_channel.sample;
      end
      clip_rd_ff <= clip_mem[k_ff];
   end

endmodule

### rtl/vpr_checker.sv
module vpr_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input vpr_pkg::sample_type rsp_residual,
   input logic                rsp_last_element
);
   import vpr_pkg::*;

   // no result is offered straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // a stalled result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_residual) && $stable(rsp_last_element))
      else $error("result payload changed while stalled");

   // each request keeps the block busy, so requests are never taken back to back
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken in back-to-back cycles");

   // no new result appears while a request is still being accumulated
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid) ##1 !$rose(rsp_valid))
      else $error("result appeared during request accumulation");

endmodule

bind vector_projection_removal vpr_checker u_vpr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_channel.valid),
   .req_ready        (req_channel.ready),
   .rsp_valid        (rsp_channel.valid),
   .rsp_ready        (rsp_channel.ready),
   .rsp_residual     (rsp_channel.residual),
   .rsp_last_element (rsp_channel.last_element)
);
